[hdl/ord_pkg.sv]
`timescale 1ns / 1ps

package ord_pkg;

  localparam int unsigned DATA_W   = 8;
  localparam int unsigned LEN_W    = 16;
  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_TDATA_W = 40;

  typedef enum logic [1:0] {
    PH_TYPE   = 2'd0,
    PH_LEN_LO = 2'd1,
    PH_LEN_HI = 2'd2,
    PH_BODY   = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    CLS_TYPE   = 2'd0,
    CLS_LENGTH = 2'd1,
    CLS_BODY   = 2'd2,
    CLS_CHECK  = 2'd3
  } byte_class_t;

  typedef struct packed {
    phase_t             phase;
    logic [DATA_W-1:0]  current_kind;
    logic [LEN_W-1:0]   record_length;
    logic [LEN_W-1:0]   bytes_seen;
    logic [DATA_W-1:0]  running_sum;
    logic               error_latch;
  } frame_state_t;

  typedef struct packed {
    logic [DATA_W-1:0]  byte_value;
    byte_class_t        byte_class;
    logic [DATA_W-1:0]  record_kind;
    logic [LEN_W-1:0]   body_offset;
    logic               record_end;
    logic               sum_good;
    logic               truncated;
    logic               sticky_error;
  } ord_result_t;

endpackage

[hdl/ord_step.sv]
`timescale 1ns / 1ps

module ord_step (
  input  ord_pkg::frame_state_t          cur,
  input  logic [ord_pkg::DATA_W-1:0]     data_byte,
  input  logic                           image_last,
  output ord_pkg::frame_state_t          nxt,
  output ord_pkg::ord_result_t           res
);
  import ord_pkg::*;

  logic [DATA_W-1:0] sum;
  logic [LEN_W:0]    seen_inc;
  logic [LEN_W-1:0]  len_hi;
  logic              rec_end;
  logic              good;
  logic              trunc;
  logic              err;

  assign sum      = cur.running_sum + data_byte;
  assign seen_inc = {1'b0, cur.bytes_seen} + {{LEN_W{1'b0}}, 1'b1};
  assign len_hi   = {data_byte, cur.record_length[DATA_W-1:0]};

  always_comb begin
    nxt             = cur;
    nxt.running_sum = sum;
    res.byte_class  = CLS_TYPE;
    res.body_offset = '0;
    rec_end         = 1'b0;

    unique case (cur.phase)
      PH_TYPE: begin
        nxt.current_kind  = data_byte;
        nxt.bytes_seen    = '0;
        nxt.record_length = '0;
        nxt.phase         = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        nxt.record_length = {{(LEN_W-DATA_W){1'b0}}, data_byte};
        res.byte_class    = CLS_LENGTH;
        nxt.phase         = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        nxt.record_length = len_hi;
        res.byte_class    = CLS_LENGTH;
        // zero length: the record has no body and ends here
        if (len_hi == '0) begin
          rec_end = 1'b1;
        end else begin
          nxt.phase = PH_BODY;
        end
      end
      PH_BODY: begin
        res.body_offset = cur.bytes_seen;
        if (seen_inc >= {1'b0, cur.record_length}) begin
          res.byte_class = CLS_CHECK;
          rec_end        = 1'b1;
        end else begin
          res.byte_class = CLS_BODY;
          nxt.bytes_seen = seen_inc[LEN_W-1:0];
        end
      end
      default: begin
        nxt.phase = PH_TYPE;
      end
    endcase

    good  = rec_end && (sum == '0);
    trunc = image_last && !rec_end;
    err   = cur.error_latch || (rec_end && !good) || trunc;

    if (rec_end) begin
      nxt.phase       = PH_TYPE;
      nxt.running_sum = '0;
      nxt.bytes_seen  = '0;
    end

    // image end: restart framing and drop the error
    if (image_last) begin
      nxt.phase       = PH_TYPE;
      nxt.running_sum = '0;
      nxt.bytes_seen  = '0;
      nxt.error_latch = 1'b0;
    end else begin
      nxt.error_latch = err;
    end

    res.byte_value   = data_byte;
    res.record_kind  = nxt.current_kind;
    res.record_end   = rec_end;
    res.sum_good     = good;
    res.truncated    = trunc;
    res.sticky_error = err;
  end

endmodule

[hdl/ord_out_reg.sv]
`timescale 1ns / 1ps

module ord_out_reg (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  load,
  input  ord_pkg::ord_result_t  res_in,
  input  logic                  take,
  output logic                  valid,
  output ord_pkg::ord_result_t  res_out
);
  import ord_pkg::*;

  logic        valid_r;
  logic        valid_nxt;
  ord_result_t res_r;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload needs no reset; hold until a new transaction is loaded
  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_in;
    end
  end

  assign valid   = valid_r;
  assign res_out = res_r;

endmodule

[hdl/object_record_deframer.sv]
`timescale 1ns / 1ps

// Channel | Direction | Signals                          | Contents
// in      | input     | in_tvalid/tready/tdata/tlast     | image byte, tlast = image end
// out     | output    | out_tvalid/tready/tdata/tuser/tlast | one result per byte,
//         |           |                                  | tlast = record end
// One byte per cycle while out_tready does not stall: the framing state updates in the
// cycle a byte is taken and its result sits in the output register on the next cycle.
// The output register is the only pipeline stage.
// Synchronous active-low reset returns framing to the type byte and clears the error.
// A stall on out_tready holds the result and drops in_tready until it is taken.
module object_record_deframer (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [ord_pkg::IN_TDATA_W-1:0]    in_tdata,   // [7:0] data_byte
  input  logic                              in_tlast,   // image_last
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [ord_pkg::OUT_TDATA_W-1:0]   out_tdata,  // [7:0] byte_value, [15:8]
                                                        // record_kind, [31:16] body_offset,
                                                        // [32] sum_good, [33] truncated,
                                                        // [34] sticky_error, [39:35] zero
  output logic [1:0]                        out_tuser,  // [1:0] byte_class
  output logic                              out_tlast   // record_end
);
  import ord_pkg::*;

  frame_state_t state_r;
  frame_state_t state_nxt;
  ord_result_t  step_res;
  ord_result_t  out_res;
  logic         in_accept;

  assign in_tready = !out_tvalid || out_tready;
  assign in_accept = in_tvalid && in_tready;

  ord_step u_step (
    .cur        (state_r),
    .data_byte  (in_tdata[DATA_W-1:0]),
    .image_last (in_tlast),
    .nxt        (state_nxt),
    .res        (step_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '{phase: PH_TYPE, current_kind: '0, record_length: '0,
                   bytes_seen: '0, running_sum: '0, error_latch: 1'b0};
    end else if (in_accept) begin
      state_r <= state_nxt;
    end
  end

  ord_out_reg u_out (
    .clk     (clk),
    .rst_n   (rst_n),
    .load    (in_accept),
    .res_in  (step_res),
    .take    (out_tready),
    .valid   (out_tvalid),
    .res_out (out_res)
  );

  assign out_tdata = {5'd0, out_res.sticky_error, out_res.truncated, out_res.sum_good,
                      out_res.body_offset, out_res.record_kind, out_res.byte_value};
  assign out_tuser = out_res.byte_class;
  assign out_tlast = out_res.record_end;

endmodule
